// ===== rtl/core/indexed_shift_list_assert.svh =====
// assertion macros shared by the indexed shift list rtl
// no dependencies; taken in by `include where checks are written

`ifndef INDEXED_SHIFT_LIST_ASSERT_SVH
`define INDEXED_SHIFT_LIST_ASSERT_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ISL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("indexed_shift_list check failed");

// next-cycle implication
`define ISL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("indexed_shift_list check failed");

`endif

// ===== rtl/core/isl_pkg.sv =====
// types and constants of the indexed shift list
// no dependencies; used by every module of the block

package isl_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned POS_W     = 6;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned COUNT_W   = 5;

	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	// what every cell of the chain does in one cycle
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_REMOVE = 2'd2
	} cell_op_t;

	// decode result handed from the controller to the top level
	typedef struct packed {
		cell_op_t op;
		status_t  status;
		logic     take;
	} isl_ctl_t;

endpackage

// ===== rtl/core/isl_cell.sv =====
// one entry cell of the indexed shift list chain
// depends on isl_pkg

module isl_cell #(
	parameter int unsigned DEPTH = isl_pkg::DEPTH_DEF,
	parameter int unsigned IDX   = 0
) (
	input  logic                        clk,
	input  isl_pkg::cell_op_t           op,
	input  logic [$clog2(DEPTH)-1:0]    idx,
	input  logic [isl_pkg::WORD_W-1:0]  word,
	input  logic [isl_pkg::WORD_W-1:0]  left,
	input  logic [isl_pkg::WORD_W-1:0]  right,
	output logic [isl_pkg::WORD_W-1:0]  data,
	output logic [isl_pkg::WORD_W-1:0]  rd_data
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [isl_pkg::WORD_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			isl_pkg::CELL_INSERT: begin
				if (MY_IDX == idx) begin
					data_q <= word;
				end else if (MY_IDX > idx) begin
					data_q <= left;
				end
			end
			isl_pkg::CELL_REMOVE: begin
				if (MY_IDX >= idx) begin
					data_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign data    = data_q;
	// only the addressed cell drives the read bus
	assign rd_data = (MY_IDX == idx) ? data_q : '0;

endmodule

// ===== rtl/core/isl_ctrl.sv =====
// controller of the indexed shift list: entry count, position mapping, range checks
// depends on isl_pkg and indexed_shift_list_assert.svh

`include "indexed_shift_list_assert.svh"

module isl_ctrl #(
	parameter int unsigned DEPTH = isl_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [isl_pkg::KIND_W-1:0]    kind,
	input  logic [isl_pkg::POS_W-1:0]     position,
	output isl_pkg::isl_ctl_t             ctl,
	output logic [$clog2(DEPTH)-1:0]      idx,
	output logic [isl_pkg::COUNT_W-1:0]   count_after
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned KW = ((CW > isl_pkg::POS_W) ? CW : isl_pkg::POS_W) + 1;

	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_nxt;
	logic signed [KW-1:0] cnt_s;
	logic signed [KW-1:0] pos_s;
	logic signed [KW-1:0] k_s;
	logic                 full;
	logic                 ins_ok;
	logic                 rr_ok;

	assign cnt_s  = signed'({{(KW-CW){1'b0}}, count_q});
	assign pos_s  = signed'({{(KW-isl_pkg::POS_W){position[isl_pkg::POS_W-1]}}, position});
	// negative positions count back from the end
	assign k_s    = pos_s[KW-1] ? (cnt_s + pos_s) : pos_s;
	assign full   = (count_q >= CW'(DEPTH));
	assign ins_ok = !pos_s[KW-1] && (pos_s <= cnt_s);
	assign rr_ok  = !k_s[KW-1] && (k_s < cnt_s);

	always_comb begin
		ctl.op     = isl_pkg::CELL_HOLD;
		ctl.status = isl_pkg::ST_OK;
		ctl.take   = 1'b0;
		idx        = '0;
		count_nxt  = count_q;
		case (isl_pkg::kind_t'(kind))
			isl_pkg::KIND_APPEND: begin
				if (full) begin
					ctl.status = isl_pkg::ST_FULL;
				end else begin
					ctl.op    = isl_pkg::CELL_INSERT;
					idx       = count_q[IW-1:0];
					count_nxt = count_q + CW'(1);
				end
			end
			isl_pkg::KIND_INSERT: begin
				if (full) begin
					ctl.status = isl_pkg::ST_FULL;
				end else if (!ins_ok) begin
					ctl.status = isl_pkg::ST_BAD;
				end else begin
					ctl.op    = isl_pkg::CELL_INSERT;
					idx       = pos_s[IW-1:0];
					count_nxt = count_q + CW'(1);
				end
			end
			isl_pkg::KIND_REMOVE: begin
				if (!rr_ok) begin
					ctl.status = isl_pkg::ST_BAD;
				end else begin
					ctl.op    = isl_pkg::CELL_REMOVE;
					ctl.take  = 1'b1;
					idx       = k_s[IW-1:0];
					count_nxt = count_q - CW'(1);
				end
			end
			isl_pkg::KIND_READ: begin
				if (!rr_ok) begin
					ctl.status = isl_pkg::ST_BAD;
				end else begin
					ctl.take = 1'b1;
					idx      = k_s[IW-1:0];
				end
			end
			default: begin
				ctl.status = isl_pkg::ST_BAD;
			end
		endcase
		// cells move only on an accepted word
		if (!fire) begin
			ctl.op = isl_pkg::CELL_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_nxt;
		end
	end

	assign count_after = isl_pkg::COUNT_W'(count_nxt);

	`ISL_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`ISL_ASSERT_IMP(a_full_only_at_depth, clk, arst_n, fire && ctl.status == isl_pkg::ST_FULL, count_q == CW'(DEPTH))
	`ISL_ASSERT_NXT(a_insert_grows, clk, arst_n, fire && ctl.op == isl_pkg::CELL_INSERT, count_q == $past(count_q) + CW'(1))
	`ISL_ASSERT_NXT(a_idle_holds, clk, arst_n, !fire, $stable(count_q))

endmodule

// ===== rtl/core/indexed_shift_list.sv =====
// top level of the indexed shift list: chain of entry cells plus output register
// depends on isl_pkg, isl_ctrl and isl_cell

//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  in      | input     | in_valid / in_ready | kind, position, element_value
//  out     | output    | out_valid/out_ready | result_value, status, entry_count
//
// every operation finishes in the cycle it is accepted; its result word shows
// on the next cycle, so one word per cycle is taken while out_ready stays high
// the rate is set by the cell chain: all cells shift together at the same clock edge
// reset clears the entry count and the output valid; cell contents and the output payload are not reset
// while a result word waits with out_ready low the output register holds and in_ready drops

module indexed_shift_list #(
	parameter int unsigned DEPTH = isl_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [isl_pkg::KIND_W-1:0]    kind,
	input  logic [isl_pkg::POS_W-1:0]     position,
	input  logic [isl_pkg::WORD_W-1:0]    element_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [isl_pkg::WORD_W-1:0]    result_value,
	output logic [isl_pkg::STATUS_W-1:0]  status,
	output logic [isl_pkg::COUNT_W-1:0]   entry_count
);

	localparam int unsigned IW = $clog2(DEPTH);

	logic                         fire;
	isl_pkg::isl_ctl_t            ctl;
	logic [IW-1:0]                idx;
	logic [isl_pkg::COUNT_W-1:0]  count_after;
	logic [isl_pkg::WORD_W-1:0]   cell_data [DEPTH];
	logic [isl_pkg::WORD_W-1:0]   cell_rd   [DEPTH];
	logic [isl_pkg::WORD_W-1:0]   rd_word;

	logic                         out_valid_q;
	logic [isl_pkg::WORD_W-1:0]   result_value_q;
	isl_pkg::status_t             status_q;
	logic [isl_pkg::COUNT_W-1:0]  entry_count_q;

	// take a new word whenever the output register is free or being emptied
	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	isl_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.kind        (kind),
		.position    (position),
		.ctl         (ctl),
		.idx         (idx),
		.count_after (count_after)
	);

	// cell i takes from i-1 on insert and from i+1 on remove
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [isl_pkg::WORD_W-1:0] left_w;
		logic [isl_pkg::WORD_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		isl_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk     (clk),
			.op      (ctl.op),
			.idx     (idx),
			.word    (element_value),
			.left    (left_w),
			.right   (right_w),
			.data    (cell_data[i]),
			.rd_data (cell_rd[i])
		);
	end

	// read bus: at most one cell drives a nonzero word
	always_comb begin
		rd_word = '0;
		for (int unsigned i = 0; i < DEPTH; i++) begin
			rd_word = rd_word | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload of the result word; zero value unless a read or remove succeeded
	always_ff @(posedge clk) begin
		if (fire) begin
			result_value_q <= ctl.take ? rd_word : '0;
			status_q       <= ctl.status;
			entry_count_q  <= count_after;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign status       = status_q;
	assign entry_count  = entry_count_q;

endmodule
